/* design/url_percent_decoder_core_macros.svh */
// assertion helpers for the checker file
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked on every clock edge, reset included
`define UPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* design/upd_pkg.sv */
package upd_pkg;

  // character codes
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // escape tracking
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  // one word of work for the back end: up to three output characters
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      cnt;
    logic            is_end;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // value of a hex digit character (only meaningful when is_hex holds)
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    hex_nibble = c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

/* design/upd_front.sv */
module upd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_char_i,
  output logic          push_o,
  output upd_pkg::cmd_t cmd_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic            hex;
  logic            pl_cnt;
  logic [7:0]      pl_char;
  logic            pl_end;
  logic [7:0]      dec_byte;

  assign hex      = upd_pkg::is_hex(in_char_i);
  assign dec_byte = {upd_pkg::hex_nibble(held_q), upd_pkg::hex_nibble(in_char_i)};

  // next escape state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept_i) begin
      unique case (phase_q)
        upd_pkg::PH_PCT: begin
          if (hex) begin
            held_d  = in_char_i;
            phase_d = upd_pkg::PH_DIGIT;
          end else begin
            phase_d = (in_char_i == upd_pkg::CHAR_PCT) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
          end
        end
        upd_pkg::PH_DIGIT: begin
          held_d  = '0;
          phase_d = (!hex && in_char_i == upd_pkg::CHAR_PCT) ? upd_pkg::PH_PCT
                                                              : upd_pkg::PH_IDLE;
        end
        default: begin
          phase_d = (in_char_i == upd_pkg::CHAR_PCT) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // plain decode of the incoming character with nothing pending
  always_comb begin
    pl_cnt  = 1'b1;
    pl_char = in_char_i;
    pl_end  = 1'b0;
    priority if (in_char_i == upd_pkg::CHAR_NUL) begin
      pl_end = 1'b1;
    end else if (in_char_i == upd_pkg::CHAR_PLUS) begin
      pl_char = upd_pkg::CHAR_SPACE;
    end else if (in_char_i == upd_pkg::CHAR_PCT) begin
      pl_cnt = 1'b0;
    end
  end

  // build the output word for the back end
  always_comb begin
    cmd_o = '0;
    unique case (phase_q)
      upd_pkg::PH_PCT: begin
        if (!hex) begin
          cmd_o.chars[0] = upd_pkg::CHAR_PCT;
          cmd_o.chars[1] = pl_char;
          cmd_o.cnt      = 2'd1 + {1'b0, pl_cnt};
          cmd_o.is_end   = pl_end;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (hex && dec_byte != upd_pkg::CHAR_NUL) begin
          cmd_o.chars[0] = dec_byte;
          cmd_o.cnt      = 2'd1;
        end else if (hex) begin
          // escape of zero goes out literally
          cmd_o.chars[0] = upd_pkg::CHAR_PCT;
          cmd_o.chars[1] = held_q;
          cmd_o.chars[2] = in_char_i;
          cmd_o.cnt      = 2'd3;
        end else begin
          cmd_o.chars[0] = upd_pkg::CHAR_PCT;
          cmd_o.chars[1] = held_q;
          cmd_o.chars[2] = pl_char;
          cmd_o.cnt      = 2'd2 + {1'b0, pl_cnt};
          cmd_o.is_end   = pl_end;
        end
      end
      default: begin
        cmd_o.chars[0] = pl_char;
        cmd_o.cnt      = {1'b0, pl_cnt};
        cmd_o.is_end   = pl_end;
      end
    endcase
  end

  assign push_o = accept_i && (cmd_o.cnt != 2'd0);

  // escape state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* design/upd_queue.sv */
module upd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upd_pkg::cmd_t   cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output upd_pkg::qhead_t head_o
);

  upd_pkg::cmd_t                mem_q [upd_pkg::QDEPTH];
  logic [upd_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [upd_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [upd_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o       = (count_q == upd_pkg::QCNT_W'(upd_pkg::QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == upd_pkg::QPTR_W'(upd_pkg::QDEPTH - 1)) ? '0
               : wr_ptr_q + upd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == upd_pkg::QPTR_W'(upd_pkg::QDEPTH - 1)) ? '0
               : rd_ptr_q + upd_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + upd_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - upd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* design/upd_back.sv */
module upd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  upd_pkg::qhead_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            string_end_o,
  output logic            run_last_o
);

  upd_pkg::cmd_t cur_q, cur_d;
  logic          cur_valid_q, cur_valid_d;
  logic [1:0]    idx_q, idx_d;
  logic          fire, last;

  assign last = (idx_q == cur_q.cnt - 2'd1);
  assign fire = cur_valid_q && !out_stall_i;

  // take a new word when empty or when the final character of the run leaves
  assign pop_o = head_i.valid && (!cur_valid_q || (fire && last));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_d       = head_i.cmd;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (fire && last) begin
      cur_valid_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // output word comes straight from the held run
  assign out_valid_o  = cur_valid_q;
  assign out_char_o   = cur_q.chars[idx_q];
  assign run_last_o   = last;
  assign string_end_o = cur_q.is_end && last;

endmodule

/* design/url_percent_decoder_core.sv */
// Streaming URL percent decoder.
// Input channel: in_valid_i / in_stall_o carry one raw character per word on
// in_char_i; a zero character ends the string. Output channel: out_valid_o /
// out_stall_i carry one decoded character per word with string_end_o on the
// terminating zero and run_last_o on the last word caused by an input word.
// An input word gives zero to three output words.
// With the queue and output stage empty, the first output of an input word passes
// through the queue and then the output-stage register. The core takes one input
// word per cycle while each makes at most one output and out_stall_i is low; the
// output side emits one word per cycle while not stalled, so an input making a run
// of n words occupies the output until all n have left. The rate is set by the
// output stage, which sends one character a cycle, and by a two-entry queue
// between the front end and the output stage. Reset clears the pending escape,
// empties the queue and drops out_valid_o. When the receiver stalls, the current
// output word holds steady, the queue fills, and in_stall_o rises once it is full.
module url_percent_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       string_end_o,
  output logic       run_last_o
);

  upd_pkg::cmd_t   cmd;
  upd_pkg::qhead_t head;
  logic            push, pop, full, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // classify characters and track escapes
  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (in_char_i),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // decouple front from output
  upd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // emit the characters one word at a time
  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .string_end_o (string_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

/* design/upd_checker.sv */
`include "url_percent_decoder_core_macros.svh"

module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_char_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       string_end_o,
  input logic       run_last_o
);

  // stalled output word holds
  `UPD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) && $stable(string_end_o) && $stable(run_last_o), "stalled output changed")

  // end of string closes the run
  `UPD_ASSERT(a_end_last, out_valid_o && string_end_o |-> run_last_o, "string end not last of run")

  // zero character only as end of string
  `UPD_ASSERT(a_end_zero, out_valid_o |-> (string_end_o == (out_char_o == 8'h00)), "zero char and end flag disagree")

  // a run continues without gaps
  `UPD_ASSERT(a_run_cont, out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o, "gap inside a run")

  // nothing leaves during reset
  `UPD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (.*);

/* tb/upd_decode_checker.sv */
// watches both channels of the percent decoder, predicts every output word
// from the accepted input words and compares them in order
module upd_decode_checker
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_char_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic       string_end_i,
  input  logic       run_last_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       str_end;
    logic       last;
  } dec_word_t;

  dec_word_t  expected_words[$];
  dec_word_t  run_words[$];
  phase_e     esc_phase;
  logic [7:0] held_char;
  int         mismatches = 0;
  int         pending_n = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_n;

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h61 + 8'd10;
    end else begin
      t = c - 8'h41 + 8'd10;
    end
    return t[3:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic emit_char(input logic [7:0] ch, input logic str_end);
    dec_word_t w;
    w.ch      = ch;
    w.str_end = str_end;
    w.last    = 1'b0;
    run_words.push_back(w);
  endtask

  // character seen with no escape pending
  task automatic plain_char(input logic [7:0] c);
    if (c == CHAR_NUL) begin
      emit_char(CHAR_NUL, 1'b1);
    end else if (c == CHAR_PLUS) begin
      emit_char(CHAR_SPACE, 1'b0);
    end else if (c == CHAR_PCT) begin
      esc_phase = PH_PCT;
    end else begin
      emit_char(c, 1'b0);
    end
  endtask

  // expected output run of one input word
  task automatic decode_word(input logic [7:0] c);
    logic [7:0] d;
    logic [7:0] v;
    run_words.delete();
    case (esc_phase)
      PH_PCT: begin
        if (hex_char(c)) begin
          held_char = c;
          esc_phase = PH_DIGIT;
        end else begin
          esc_phase = PH_IDLE;
          emit_char(CHAR_PCT, 1'b0);
          plain_char(c);
        end
      end
      PH_DIGIT: begin
        d = held_char;
        esc_phase = PH_IDLE;
        held_char = 8'h00;
        if (hex_char(c)) begin
          v = {digit_value(d), digit_value(c)};
          if (v != 8'h00) begin
            emit_char(v, 1'b0);
          end else begin
            // escape of zero goes out literally
            emit_char(CHAR_PCT, 1'b0);
            emit_char(d, 1'b0);
            emit_char(c, 1'b0);
          end
        end else begin
          emit_char(CHAR_PCT, 1'b0);
          emit_char(d, 1'b0);
          plain_char(c);
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        plain_char(c);
      end
    endcase
    if (run_words.size() > 0) begin
      run_words[run_words.size() - 1].last = 1'b1;
    end
    foreach (run_words[i]) begin
      expected_words.push_back(run_words[i]);
    end
  endtask

  // predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    dec_word_t w;
    if (!rst_ni) begin
      esc_phase = PH_IDLE;
      held_char = 8'h00;
      expected_words.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_word(in_char_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected output word char %h end %b last %b",
                                    out_char_i, string_end_i, run_last_i));
        end else begin
          w = expected_words.pop_front();
          if (out_char_i !== w.ch) begin
            report_mismatch($sformatf("out_char %h, predicted %h", out_char_i, w.ch));
          end
          if (string_end_i !== w.str_end) begin
            report_mismatch($sformatf("string_end %b, predicted %b (char %h)",
                                      string_end_i, w.str_end, w.ch));
          end
          if (run_last_i !== w.last) begin
            report_mismatch($sformatf("run_last %b, predicted %b (char %h)",
                                      run_last_i, w.last, w.ch));
          end
        end
      end
    end
    pending_n = expected_words.size();
  end

endmodule

/* tb/url_percent_decoder_core_tb.sv */
// stimulus and verdict for the percent decoder
module url_percent_decoder_core_tb;
  import upd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 65;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] in_char    = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char;
  logic       string_end;
  logic       run_last;

  int idle_pct  = 0;
  int stall_pct = 0;
  int fail_count;
  int pending;
  int cycles    = 0;
  int sent      = 0;

  // directed words: plain, plus, escapes of both cases, escape of zero,
  // bad escapes, high bytes, end of string alone and with escape pending
  logic [7:0] directed_words[] = '{
    8'h61, 8'h2B,
    8'h25, 8'h66, 8'h46,
    8'h25, 8'h30, 8'h30,
    8'h25, 8'h47,
    8'h25, 8'h34, 8'h7A,
    8'h25, 8'h25, 8'h34, 8'h31,
    8'h80, 8'hFF,
    8'h00,
    8'h25, 8'h00,
    8'h25, 8'h61, 8'h00
  };

  url_percent_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_char_i    (in_char),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_char_o   (out_char),
    .string_end_o (string_end),
    .run_last_o   (run_last)
  );

  upd_decode_checker u_decode_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_char_i    (in_char),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_char_i   (out_char),
    .string_end_i (string_end),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("url_percent_decoder_core regression: fail");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one word through the input handshake, with random idle gaps first
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(21);
    if (n < 10) return 8'h30 + n[7:0];
    if (n < 16) return 8'h41 + n[7:0] - 8'd10;
    return 8'h61 + n[7:0] - 8'd16;
  endfunction

  // mostly well-formed escapes and text, some broken escapes and ends
  task automatic send_random_token();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) begin
      send_char(8'($urandom_range(1, 255)));
    end else if (roll < 40) begin
      send_char(CHAR_PLUS);
    end else if (roll < 70) begin
      send_char(CHAR_PCT);
      send_char(rand_hex());
      send_char(rand_hex());
    end else if (roll < 74) begin
      send_char(CHAR_PCT);
      send_char(8'h30);
      send_char(8'h30);
    end else if (roll < 82) begin
      send_char(CHAR_PCT);
      send_char(8'($urandom_range(255)));
    end else if (roll < 90) begin
      send_char(CHAR_PCT);
      send_char(rand_hex());
      send_char(8'($urandom_range(255)));
    end else begin
      send_char(CHAR_NUL);
    end
  endtask

  initial begin
    // falling reset edge at start so the flops clear before the first clock
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) begin
      send_char(directed_words[i]);
    end

    // idling phases: none, sender, receiver, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) send_random_token();
    end
    in_valid <= 1'b0;

    // drain
    stall_pct = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("url_percent_decoder_core regression: pass");
    end else begin
      $display("url_percent_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
